@@ rtl/fsa_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsa_pkg
// Shared types and constants of the FAT12 sector allocator.
// ----------------------------------------------------------------------------
package fsa_pkg;

   localparam int ENTRY_W = 12;   // table entry width
   localparam int IDX_W   = 12;   // entry index width on the request
   localparam int SEC_W   = 13;   // 1-based sector number
   localparam int FREE_W  = 22;   // free space in bytes
   localparam int TS_W    = 4;    // table_sectors register width

   localparam logic [ENTRY_W-1:0] END_MARK = 12'hfff;

   typedef enum logic [1:0] {
      KIND_READ  = 2'd0,
      KIND_WRITE = 2'd1,
      KIND_ALLOC = 2'd2,
      KIND_QUERY = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type             kind;
      logic [IDX_W-1:0]     entry_addr;
      logic [ENTRY_W-1:0]   entry_value;
      logic                 link_previous;
   } req_type;

   typedef struct packed {
      logic [ENTRY_W-1:0]   read_value;
      logic [SEC_W-1:0]     allocated_sector;
      logic                 table_full;
      logic [FREE_W-1:0]    free_bytes;
   } rsp_type;

   // single port table access
   typedef struct packed {
      logic                 we;
      logic                 re;
      logic [IDX_W-1:0]     addr;
      logic [ENTRY_W-1:0]   wdata;
   } ram_req_type;

endpackage

@@ rtl/fsa_table_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsa_table_ram
// Single port allocation table memory, registered read data.
// ----------------------------------------------------------------------------
module fsa_table_ram #(
   parameter int DEPTH = 4096
) (
   input  logic                          clock,
   input  fsa_pkg::ram_req_type          ram_req,
   output logic [fsa_pkg::ENTRY_W-1:0]   ram_rdata
);
   import fsa_pkg::*;

   localparam int ADDR_W = $clog2(DEPTH);

   logic [ENTRY_W-1:0] mem [DEPTH];
   logic [ADDR_W-1:0]  addr;

   assign addr = ram_req.addr[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (ram_req.we) begin
         mem[addr] <= ram_req.wdata;
      end
      if (ram_req.re) begin
         ram_rdata <= mem[addr];
      end
   end

endmodule

@@ rtl/fsa_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fsa_ctrl
// Sequencer: clearing pass, entry access, allocate scan, free-space count.
// ----------------------------------------------------------------------------
module fsa_ctrl #(
   parameter int MAX_ENTRIES  = 4096,
   parameter int SECTOR_BYTES = 512
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  fsa_pkg::req_type                      req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output fsa_pkg::rsp_type                      rsp_data,
   input  logic [$clog2(MAX_ENTRIES+1)-1:0]      in_use,
   output fsa_pkg::ram_req_type                  ram_req,
   input  logic [fsa_pkg::ENTRY_W-1:0]           ram_rdata
);
   import fsa_pkg::*;

   localparam int ADDR_W = $clog2(MAX_ENTRIES);
   localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);

   typedef enum logic [6:0] {
      S_CLEAR = 7'b0000001,
      S_IDLE  = 7'b0000010,
      S_READ  = 7'b0000100,
      S_SCAN  = 7'b0001000,
      S_MARK  = 7'b0010000,
      S_LINK  = 7'b0100000,
      S_DONE  = 7'b1000000
   } state_type;

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [CNT_W-1:0]  scan_ff, scan_in;
   logic              pend_ff, pend_in;
   logic [ADDR_W-1:0] raddr_ff, raddr_in;
   logic [CNT_W-1:0]  zero_ff, zero_in;
   logic [ADDR_W-1:0] found_ff, found_in;
   kind_type          kind_ff, kind_in;
   logic              link_ff, link_in;
   logic              idx_ok_ff, idx_ok_in;
   rsp_type           res_ff, res_in;
   logic [SEC_W-1:0]  last_ff, last_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_ff, rsp_in;

   logic              accept;
   logic              idx_ok;
   logic              issue;
   logic              hit;
   logic              scan_end;
   logic [SEC_W-1:0]  sector;
   logic [SEC_W-1:0]  last_m1;
   logic              link_ok;

   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && !req_stall;
   assign idx_ok    = {1'b0, req_data.entry_addr} < (IDX_W + 1)'(MAX_ENTRIES);
   assign issue     = scan_ff < in_use;
   assign hit       = pend_ff && (ram_rdata == '0);
   assign scan_end  = !issue && !pend_ff;
   assign sector    = SEC_W'(found_ff) + SEC_W'(1);
   assign last_m1   = last_ff - SEC_W'(1);
   assign link_ok   = link_ff && (last_ff != '0) && (last_m1 < SEC_W'(MAX_ENTRIES));

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      scan_in      = scan_ff;
      pend_in      = pend_ff;
      raddr_in     = raddr_ff;
      zero_in      = zero_ff;
      found_in     = found_ff;
      kind_in      = kind_ff;
      link_in      = link_ff;
      idx_ok_in    = idx_ok_ff;
      res_in       = res_ff;
      last_in      = last_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      ram_req      = '0;

      case (state_ff)
         S_CLEAR: begin
            ram_req.we    = 1'b1;
            ram_req.addr  = IDX_W'(clr_ff);
            ram_req.wdata = '0;
            clr_in        = clr_ff + ADDR_W'(1);
            if (clr_ff == ADDR_W'(MAX_ENTRIES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               kind_in   = req_data.kind;
               link_in   = req_data.link_previous;
               idx_ok_in = idx_ok;
               res_in    = '0;
               scan_in   = '0;
               pend_in   = 1'b0;
               zero_in   = '0;
               case (req_data.kind)
                  KIND_READ: begin
                     ram_req.re   = 1'b1;
                     ram_req.addr = req_data.entry_addr;
                     state_in     = S_READ;
                  end
                  KIND_WRITE: begin
                     ram_req.we    = idx_ok;
                     ram_req.addr  = req_data.entry_addr;
                     ram_req.wdata = req_data.entry_value;
                     state_in      = S_DONE;
                  end
                  KIND_ALLOC, KIND_QUERY: begin
                     state_in = S_SCAN;
                  end
                  default: begin
                     state_in = S_DONE;
                  end
               endcase
            end
         end
         S_READ: begin
            res_in.read_value = idx_ok_ff ? ram_rdata : '0;
            state_in          = S_DONE;
         end
         S_SCAN: begin
            // one read issued per cycle, its data checked in the cycle after
            pend_in = issue;
            if (issue) begin
               ram_req.re   = 1'b1;
               ram_req.addr = IDX_W'(scan_ff[ADDR_W-1:0]);
               raddr_in     = scan_ff[ADDR_W-1:0];
               scan_in      = scan_ff + CNT_W'(1);
            end
            if (kind_ff == KIND_ALLOC) begin
               if (hit) begin
                  found_in = raddr_ff;
                  pend_in  = 1'b0;
                  state_in = S_MARK;
               end else if (scan_end) begin
                  res_in.table_full = 1'b1;
                  state_in          = S_DONE;
               end
            end else begin
               if (hit) begin
                  zero_in = zero_ff + CNT_W'(1);
               end
               if (scan_end) begin
                  res_in.free_bytes = FREE_W'(32'(zero_ff) * 32'(SECTOR_BYTES));
                  state_in          = S_DONE;
               end
            end
         end
         S_MARK: begin
            ram_req.we              = 1'b1;
            ram_req.addr            = IDX_W'(found_ff);
            ram_req.wdata           = END_MARK;
            res_in.allocated_sector = sector;
            if (link_ok) begin
               state_in = S_LINK;
            end else begin
               last_in  = sector;
               state_in = S_DONE;
            end
         end
         S_LINK: begin
            // after the end mark, so a link onto the new entry wins
            ram_req.we    = 1'b1;
            ram_req.addr  = IDX_W'(last_m1[ADDR_W-1:0]);
            ram_req.wdata = sector[ENTRY_W-1:0];
            last_in       = sector;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         pend_ff      <= 1'b0;
         last_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         pend_ff      <= pend_in;
         last_ff      <= last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff   <= scan_in;
      raddr_ff  <= raddr_in;
      zero_ff   <= zero_in;
      found_ff  <= found_in;
      kind_ff   <= kind_in;
      link_ff   <= link_in;
      idx_ok_ff <= idx_ok_in;
      res_ff    <= res_in;
      rsp_ff    <= rsp_in;
   end

   // the entry being marked was read back as free
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MARK) |-> ($past(ram_rdata) == '0))
      else $error("allocate marks an entry that was not free");

   // free count can never pass the number of entries read
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (zero_ff <= scan_ff))
      else $error("free count ahead of scan");

   // mark is followed by link or completion only
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MARK) |=> (state_ff == S_LINK || state_ff == S_DONE))
      else $error("bad sequence after mark");

   // a finished item reaches the output register
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && (!rsp_valid_ff || !rsp_stall)) |=> rsp_valid_ff)
      else $error("result not loaded");

endmodule

@@ rtl/fat12_sector_allocator_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fat12_sector_allocator_unit
// FAT12 allocation table with entry access, allocate and free-space query.
// ----------------------------------------------------------------------------
// After reset the block runs a clearing pass that writes every table entry
// free; req_stall stays high during it, while csr writes are taken as usual.
// The table lives in one single-port synchronous memory, which allows one
// access per cycle. A read passes S_READ, then S_DONE, before its result goes
// to the output register, a write straight to S_DONE. Allocate and query
// scan entries 0 .. n-1, where n = floor(table_sectors*SECTOR_BYTES/3)*2
// capped at MAX_ENTRIES: a query counts the free entries among all n, an
// allocate stops at the first free entry and marks it (then links the
// previous sector onto it when link_previous is set and a previous sector is
// known), and a full table gives table_full once all n entries are read. One
// item is in work at a time; a finished item waits in the output register, so
// the next item can be accepted while it is still stalled on rsp.
// ----------------------------------------------------------------------------
module fat12_sector_allocator_unit #(
   parameter int MAX_ENTRIES  = 4096,
   parameter int SECTOR_BYTES = 512
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  fsa_pkg::req_type            req_data,
   // result channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output fsa_pkg::rsp_type            rsp_data,
   // table_sectors register
   input  logic                        csr_we,
   input  logic [fsa_pkg::TS_W-1:0]    csr_wdata
);
   import fsa_pkg::*;

   localparam int              CNT_W   = $clog2(MAX_ENTRIES + 1);
   localparam int              LUT_N   = 1 << TS_W;
   localparam logic [TS_W-1:0] TS_RST  = TS_W'(1);

   // in-use entry count per table_sectors value, all worked out at elaboration
   logic [CNT_W-1:0] in_use_lut [LUT_N];

   for (genvar g = 0; g < LUT_N; g++) begin : g_lut
      localparam int Raw    = (g * SECTOR_BYTES) / 3 * 2;
      localparam int Capped = (Raw > MAX_ENTRIES) ? MAX_ENTRIES : Raw;
      assign in_use_lut[g] = CNT_W'(Capped);
   end

   // the register keeps the decoded in-use count rather than the raw value
   logic [CNT_W-1:0] in_use_ff, in_use_in;

   assign in_use_in = csr_we ? in_use_lut[csr_wdata] : in_use_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff <= in_use_lut[TS_RST];
      end else begin
         in_use_ff <= in_use_in;
      end
   end

   ram_req_type         ram_req;
   logic [ENTRY_W-1:0]  ram_rdata;

   fsa_ctrl #(
      .MAX_ENTRIES  (MAX_ENTRIES),
      .SECTOR_BYTES (SECTOR_BYTES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .in_use    (in_use_ff),
      .ram_req   (ram_req),
      .ram_rdata (ram_rdata)
   );

   fsa_table_ram #(
      .DEPTH (MAX_ENTRIES)
   ) u_table (
      .clock     (clock),
      .ram_req   (ram_req),
      .ram_rdata (ram_rdata)
   );

endmodule
